/* src/sequential_list_engine_defines.svh */
// ----------------------------------------------------------------------------
// Sequential list engine: assertion macros
// Shared property wrappers used by the RTL of the list engine.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_DEFINES_SVH

// same-cycle implication
`define SLE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SLE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/sle_pkg.sv */
// ----------------------------------------------------------------------------
// Sequential list engine package
// Beat types, command and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package sle_pkg;

   localparam logic [2:0] CMD_INSERT  = 3'd0;
   localparam logic [2:0] CMD_DELETE  = 3'd1;
   localparam logic [2:0] CMD_FIND    = 3'd2;
   localparam logic [2:0] CMD_REVERSE = 3'd3;
   localparam logic [2:0] CMD_DUMP    = 3'd4;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_BAD_POS   = 3'd1;
   localparam logic [2:0] STAT_FULL      = 3'd2;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [2:0] STAT_EMPTY     = 3'd4;

   typedef struct packed {
      logic [2:0]         cmd;
      logic [6:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] word;
      logic [6:0]         found_position;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_SHIFT,
      ST_INS_PUT,
      ST_DEL_READ,
      ST_DEL_CAP,
      ST_DEL_SHIFT,
      ST_SCAN,
      ST_SCAN_END,
      ST_REV_RI,
      ST_REV_RJ,
      ST_REV_WI,
      ST_REV_WJ,
      ST_DUMP,
      ST_DUMP_END,
      ST_FIN
   } state_type;

endpackage

/* src/sle_rsp_reg.sv */
// ----------------------------------------------------------------------------
// Sequential list engine: result register
// Holds one result beat toward the consumer and reports when it can load.
// ----------------------------------------------------------------------------
module sle_rsp_reg (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  sle_pkg::rsp_type beat,
   output logic            can_load,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output sle_pkg::rsp_type rsp_data
);
   import sle_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type beat_ff, beat_in;

   assign can_load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = load || (valid_ff && rsp_stall);
      beat_in  = load ? beat : beat_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = beat_ff;

endmodule

/* src/sequential_list_engine.sv */
// ----------------------------------------------------------------------------
// Sequential list engine
// Ordered list of signed words in one memory with a length count:
// positional insert and delete, find last match, reverse, dump.
// ----------------------------------------------------------------------------
//  channel | ports                          | beat
//  req     | req_valid req_stall req_data   | cmd, position, value
//  rsp     | rsp_valid rsp_stall rsp_data   | status, word, found_position, last
//
//  One command at a time; all work goes through the element memory, which has
//  one read and one write port: one entry per cycle is shifted or scanned, and
//  one per cycle is dumped while the output register can load.
//  Reset clears the length, the state and the valid flags; the memory is never cleared.
//  A result stalled on rsp waits in the output register; dump pauses its reads.
// ----------------------------------------------------------------------------
`include "sequential_list_engine_defines.svh"

module sequential_list_engine #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sle_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sle_pkg::rsp_type rsp_data
);
   import sle_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);
   localparam int CW = ((LW > 7) ? LW : 7) + 1;

   state_type       state_ff, state_in;
   logic [LW-1:0]   len_ff, len_in;
   logic [AW-1:0]   rp_ff, rp_in;
   logic [AW-1:0]   jp_ff, jp_in;
   logic [AW-1:0]   lim_ff, lim_in;
   logic [2:0]      op_ff, op_in;
   logic [2:0]      stat_ff, stat_in;
   logic [31:0]     hold_ff, hold_in;
   logic            mv_pend_ff, mv_pend_in;
   logic [AW-1:0]   mv_addr_ff, mv_addr_in;
   logic            cmp_v_ff, cmp_v_in;
   logic [AW-1:0]   cmp_idx_ff, cmp_idx_in;
   logic            found_ff, found_in;
   logic [6:0]      hit_ff, hit_in;
   logic            dv_ff, dv_in;
   logic            dv_last_ff, dv_last_in;

   logic [31:0]     mem [CAPACITY];
   logic [31:0]     rdata_ff;
   logic            rd_en, wr_en;
   logic [AW-1:0]   rd_addr, wr_addr;
   logic [31:0]     wr_data;

   logic            rsp_load, can_load;
   rsp_type         rsp_beat;

   logic [CW-1:0]   n_c, p_c;
   logic [AW-1:0]   nm1, pm1;
   logic            ins_bad, ins_full, ins_tail, del_bad, is_empty, is_short;
   logic            at_lim, rev_more, dv_go, dump_issue;

   assign req_stall = (state_ff != ST_IDLE);

   assign n_c      = CW'(len_ff);
   assign p_c      = CW'(req_data.position);
   assign nm1      = AW'(n_c - CW'(1));
   assign pm1      = AW'(p_c - CW'(1));
   assign ins_bad  = (p_c == '0) || (p_c > n_c + CW'(1));
   assign ins_full = (n_c == CW'(CAPACITY));
   assign ins_tail = (p_c == n_c + CW'(1));
   assign del_bad  = (p_c == '0) || (p_c > n_c);
   assign is_empty = (len_ff == '0);
   assign is_short = (n_c < CW'(2));
   assign at_lim   = (rp_ff == lim_ff);
   assign rev_more = (CW'(rp_ff) + CW'(2)) < CW'(jp_ff);
   assign dv_go    = dv_ff && can_load;
   assign dump_issue = (state_ff == ST_DUMP) && (!dv_ff || dv_go);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_data.cmd)
                  CMD_INSERT: begin
                     if (ins_bad || ins_full) state_in = ST_FIN;
                     else if (ins_tail)       state_in = ST_INS_PUT;
                     else                     state_in = ST_INS_SHIFT;
                  end
                  CMD_DELETE:  state_in = del_bad  ? ST_FIN : ST_DEL_READ;
                  CMD_FIND:    state_in = is_empty ? ST_FIN : ST_SCAN;
                  CMD_REVERSE: state_in = is_short ? ST_FIN : ST_REV_RI;
                  CMD_DUMP:    state_in = is_empty ? ST_FIN : ST_DUMP;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_INS_SHIFT: if (at_lim) state_in = ST_INS_PUT;
         ST_INS_PUT:   if (!mv_pend_ff) state_in = ST_FIN;
         ST_DEL_READ:  state_in = ST_DEL_CAP;
         ST_DEL_CAP:   state_in = at_lim ? ST_FIN : ST_DEL_SHIFT;
         ST_DEL_SHIFT: if (at_lim) state_in = ST_FIN;
         ST_SCAN:      if (at_lim) state_in = ST_SCAN_END;
         ST_SCAN_END:  state_in = ST_FIN;
         ST_REV_RI:    state_in = ST_REV_RJ;
         ST_REV_RJ:    state_in = ST_REV_WI;
         ST_REV_WI:    state_in = ST_REV_WJ;
         ST_REV_WJ:    state_in = rev_more ? ST_REV_RJ : ST_FIN;
         ST_DUMP:      if (dump_issue && at_lim) state_in = ST_DUMP_END;
         ST_DUMP_END:  if (dv_go) state_in = ST_IDLE;
         ST_FIN:       if (can_load) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      len_in     = len_ff;
      rp_in      = rp_ff;
      jp_in      = jp_ff;
      lim_in     = lim_ff;
      op_in      = op_ff;
      stat_in    = stat_ff;
      hold_in    = hold_ff;
      mv_pend_in = 1'b0;
      mv_addr_in = mv_addr_ff;
      cmp_v_in   = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      found_in   = found_ff;
      hit_in     = hit_ff;
      dv_last_in = dv_last_ff;
      rd_en      = 1'b0;
      rd_addr    = rp_ff;
      wr_en      = 1'b0;
      wr_addr    = lim_ff;
      wr_data    = hold_ff;
      rsp_load   = 1'b0;
      rsp_beat   = '0;

      // find compare, in the cycle after the read
      if (cmp_v_ff && (rdata_ff == hold_ff)) begin
         found_in = 1'b1;
         hit_in   = 7'(CW'(cmp_idx_ff) + CW'(1));
      end

      // shift write lands in the cycle after its read
      if (mv_pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = mv_addr_ff;
         wr_data = rdata_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.cmd;
               hold_in  = req_data.value;
               stat_in  = STAT_OK;
               found_in = 1'b0;
               hit_in   = '0;
               rp_in    = '0;
               lim_in   = nm1;
               case (req_data.cmd)
                  CMD_INSERT: begin
                     if (ins_bad) begin
                        stat_in = STAT_BAD_POS;
                     end else if (ins_full) begin
                        stat_in = STAT_FULL;
                     end else begin
                        len_in = len_ff + LW'(1);
                        lim_in = pm1;
                        rp_in  = nm1;
                     end
                  end
                  CMD_DELETE: begin
                     if (del_bad) begin
                        stat_in = STAT_BAD_POS;
                     end else begin
                        len_in = len_ff - LW'(1);
                        rp_in  = pm1;
                     end
                  end
                  CMD_REVERSE: jp_in = nm1;
                  CMD_DUMP: if (is_empty) stat_in = STAT_EMPTY;
                  default: ;
               endcase
            end
         end
         ST_INS_SHIFT: begin
            rd_en      = 1'b1;
            mv_pend_in = 1'b1;
            mv_addr_in = rp_ff + AW'(1);
            rp_in      = rp_ff - AW'(1);
         end
         ST_INS_PUT: begin
            if (!mv_pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = lim_ff;
               wr_data = hold_ff;
            end
         end
         ST_DEL_READ: rd_en = 1'b1;
         ST_DEL_CAP: begin
            hold_in = rdata_ff;
            rp_in   = rp_ff + AW'(1);
         end
         ST_DEL_SHIFT: begin
            rd_en      = 1'b1;
            mv_pend_in = 1'b1;
            mv_addr_in = rp_ff - AW'(1);
            rp_in      = rp_ff + AW'(1);
         end
         ST_SCAN: begin
            rd_en      = 1'b1;
            cmp_v_in   = 1'b1;
            cmp_idx_in = rp_ff;
            rp_in      = rp_ff + AW'(1);
         end
         ST_REV_RI: rd_en = 1'b1;
         ST_REV_RJ: begin
            hold_in = rdata_ff;
            rd_en   = 1'b1;
            rd_addr = jp_ff;
         end
         ST_REV_WI: begin
            wr_en   = 1'b1;
            wr_addr = rp_ff;
            wr_data = rdata_ff;
         end
         ST_REV_WJ: begin
            wr_en   = 1'b1;
            wr_addr = jp_ff;
            wr_data = hold_ff;
            if (rev_more) begin
               rd_en   = 1'b1;
               rd_addr = rp_ff + AW'(1);
               rp_in   = rp_ff + AW'(1);
               jp_in   = jp_ff - AW'(1);
            end
         end
         ST_DUMP: begin
            if (dump_issue) begin
               rd_en      = 1'b1;
               rp_in      = rp_ff + AW'(1);
               dv_last_in = at_lim;
            end
         end
         ST_FIN: begin
            rsp_load = can_load;
            rsp_beat.status = (op_ff == CMD_FIND) ?
                              (found_ff ? STAT_OK : STAT_NOT_FOUND) : stat_ff;
            rsp_beat.word = ((op_ff == CMD_DELETE) && (stat_ff == STAT_OK)) ?
                            hold_ff : '0;
            rsp_beat.found_position = ((op_ff == CMD_FIND) && found_ff) ? hit_ff : '0;
            rsp_beat.last = 1'b1;
         end
         default: ;
      endcase

      // dump word moves from the memory output into the result register
      if (dv_go) begin
         rsp_load        = 1'b1;
         rsp_beat.status = STAT_OK;
         rsp_beat.word   = rdata_ff;
         rsp_beat.last   = dv_last_ff;
      end
      dv_in = dump_issue ? 1'b1 : (dv_go ? 1'b0 : dv_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         len_ff     <= '0;
         mv_pend_ff <= 1'b0;
         cmp_v_ff   <= 1'b0;
         dv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         mv_pend_ff <= mv_pend_in;
         cmp_v_ff   <= cmp_v_in;
         dv_ff      <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff      <= rp_in;
      jp_ff      <= jp_in;
      lim_ff     <= lim_in;
      op_ff      <= op_in;
      stat_ff    <= stat_in;
      hold_ff    <= hold_in;
      mv_addr_ff <= mv_addr_in;
      cmp_idx_ff <= cmp_idx_in;
      found_ff   <= found_in;
      hit_ff     <= hit_in;
      dv_last_ff <= dv_last_in;
   end

   // element memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   sle_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .beat      (rsp_beat),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `SLE_ASSERT_NOW(a_len_bound, clock, reset, 1'b1, len_ff <= LW'(CAPACITY),
      "list length above capacity")
   `SLE_ASSERT_NOW(a_idle_no_write, clock, reset, state_ff == ST_IDLE, !wr_en,
      "memory write while idle")
   `SLE_ASSERT_NEXT(a_len_step, clock, reset, 1'b1,
      (len_ff == $past(len_ff)) || (len_ff == $past(len_ff) + LW'(1)) ||
      (len_ff == $past(len_ff) - LW'(1)),
      "list length moved by more than one")
   `SLE_ASSERT_NOW(a_partial_beat_in_dump, clock, reset, rsp_valid && !rsp_data.last,
      (state_ff == ST_DUMP) || (state_ff == ST_DUMP_END),
      "non-final beat outside dump")

endmodule
